[rtl/cmts_pkg.sv]
// Shared constants, codes and types of the collision mesh tally scorer.
`default_nettype none
package cmts_pkg;

   localparam int CELLS_X     = 8;
   localparam int CELLS_Y     = 8;
   localparam int CELLS_Z     = 8;
   localparam int ENERGY_BINS = 4;

   localparam int BOUND_SLOTS = ENERGY_BINS + 1;
   localparam int BIDX_W      = (BOUND_SLOTS > 1) ? $clog2(BOUND_SLOTS) : 1;
   localparam int BCNT_W      = $clog2(BOUND_SLOTS + 1);

   localparam int ADDR_W      = 11;
   localparam int STORE_DEPTH = 2048;
   localparam int VAL_W       = 48;
   localparam int NUM_W       = 96;
   localparam int DEN_W       = 48;
   localparam int DIV_STEPS   = 96;
   localparam int DCNT_W      = 7;

   localparam logic [31:0]      ONE_Q16 = 32'h0001_0000;
   localparam logic [VAL_W-1:0] TOP_POS = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] TOP_NEG = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [2:0] MODE_FLUX     = 3'd0;
   localparam logic [2:0] MODE_ELASTIC  = 3'd1;
   localparam logic [2:0] MODE_ABSORB   = 3'd2;
   localparam logic [2:0] MODE_FISSION  = 3'd3;
   localparam logic [2:0] MODE_TOTAL    = 3'd4;
   localparam logic [2:0] MODE_MT       = 3'd5;
   localparam logic [2:0] MODE_REAL     = 3'd6;
   localparam logic [2:0] MODE_IMAG     = 3'd7;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Z  = 3'd3;
   localparam logic [2:0] REG_INV_X     = 3'd4;
   localparam logic [2:0] REG_INV_Y     = 3'd5;
   localparam logic [2:0] REG_INV_Z     = 3'd6;
   localparam logic [2:0] REG_INV_NET   = 3'd7;

   typedef enum logic [1:0] {
      CMD_SCORE = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIN_CMP,
      ST_AX_MUL,
      ST_AX_CHK,
      ST_MAG,
      ST_PLO,
      ST_PHI,
      ST_NUM,
      ST_DIV,
      ST_RD,
      ST_WB,
      ST_ENT_Q,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

[rtl/cmts_div.sv]
// Bit-serial restoring divider with a saturating quotient.
`default_nettype none
module cmts_div import cmts_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [VAL_W-1:0] cap,
   output logic                  done,
   output logic [VAL_W-1:0]      quo
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [VAL_W-1:0]  cap_ff, cap_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [VAL_W:0]    q_ff, q_in;
   logic              sat_ff, sat_in;

   logic [DEN_W:0]    rem_sh;
   logic              q_bit;
   logic [VAL_W:0]    q_next;

   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, den_ff});
   assign q_next = {q_ff[VAL_W-1:0], q_bit};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cap_in  = cap_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         den_in  = den;
         cap_in  = cap;
         rem_in  = '0;
         q_in    = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = q_bit ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         if (!sat_ff) begin
            q_in = q_next;
            if (q_next > {1'b0, cap_ff}) begin
               sat_in = 1'b1;
            end
         end
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cap_ff <= cap_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quo  = sat_ff ? cap_ff : q_ff[VAL_W-1:0];

endmodule
`default_nettype wire

[rtl/collision_mesh_tally_scorer_top.sv]
// Top level of the collision mesh tally scorer: sequencer, shared multiplier and stores.
//
//   Channel   Direction  Handshake                  Payload
//   req_      in         req_tvalid / req_tready    req_tuser cmd, req_tdata fields
//   rsp_      out        rsp_tvalid / rsp_tready    rsp_tuser scored, rsp_tdata fields
//   csr_      in         csr_valid / csr_ready      csr_index, csr_data
//
// A scored word goes through the bound search, a multiply and a range check per mesh axis,
// the 96-step bit-serial divider (skipped when total_xs is zero) and the tally
// read-modify-write before its result word is offered.
// A load or unused word goes straight to ST_OUT, a read word via ST_ENT_Q; both wait for rsp_tready.
// After reset all 2048 entries of the tally store are swept to zero with req_tready low.
// One word is in work at a time; req_tready stays low until its result word is taken.
`default_nettype none
module collision_mesh_tally_scorer_top import cmts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, energy, weight, weight_imag, total_xs, reaction_xs,
   // table_index, table_value, zero fill
   input  wire logic [303:0] req_tdata,
   // cmd
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // bin_address, tally_value, zero fill
   output logic [63:0]       rsp_tdata,
   // scored
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic [2:0]  mode_ff;
   logic [31:0] org_ff [3];
   logic [31:0] inv_ff [3];
   logic [31:0] inw_ff;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [BCNT_W-1:0]  bu_ff, bu_in;

   logic [31:0]        pos_ff [3];
   logic [31:0]        pos_in [3];
   logic [31:0]        energy_ff, energy_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        f_ff, f_in;
   logic [31:0]        tot_ff, tot_in;
   logic [BCNT_W-1:0]  s_ff, s_in;
   logic [31:0]        lo_ff, lo_in;
   logic [BCNT_W-1:0]  bin_ff, bin_in;
   logic [1:0]         axis_ff, axis_in;
   logic [ADDR_W-1:0]  cell_ff [3];
   logic [ADDR_W-1:0]  cell_in [3];
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [31:0]        phi_ff, phi_in;
   logic [63:0]        plo_ff, plo_in;
   logic [VAL_W-1:0]   smag_ff, smag_in;
   logic               rsp_score_ff, rsp_score_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [VAL_W-1:0]   rsp_val_ff, rsp_val_in;

   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;

   logic [VAL_W-1:0]   store_mem [STORE_DEPTH];
   logic [VAL_W-1:0]   rdata_ff;
   logic               store_we;
   logic [ADDR_W-1:0]  store_wa, store_ra;
   logic [VAL_W-1:0]   store_wd;

   logic [31:0]        bound_mem [BOUND_SLOTS];
   logic [31:0]        bound_q_ff;
   logic               bound_we;
   logic [BIDX_W-1:0]  bound_wa, bound_ra;

   logic               div_start, div_done;
   logic [VAL_W-1:0]   div_quo;

   logic [31:0]        f_pos [3];
   logic [31:0]        f_energy, f_weight, f_weight_imag, f_total, f_react, f_tval;
   logic [ADDR_W-1:0]  f_tidx;
   logic [31:0]        w_sel;
   logic [31:0]        ax_pos, ax_org, ax_inv, ax_cells;
   logic [32:0]        ax_diff;
   logic [31:0]        cell_hi;
   logic [NUM_W-1:0]   num_sum;
   logic [VAL_W-1:0]   cap;
   logic [ADDR_W-1:0]  a0, a1, a2;
   logic [BCNT_W-1:0]  s_plus;
   logic [49:0]        old_ext, sc_ext, sum;
   logic [VAL_W-1:0]   new_val;

   assign f_pos[0]      = req_tdata[31:0];
   assign f_pos[1]      = req_tdata[63:32];
   assign f_pos[2]      = req_tdata[95:64];
   assign f_energy      = req_tdata[127:96];
   assign f_weight      = req_tdata[159:128];
   assign f_weight_imag = req_tdata[191:160];
   assign f_total       = req_tdata[223:192];
   assign f_react       = req_tdata[255:224];
   assign f_tidx        = req_tdata[266:256];
   assign f_tval        = req_tdata[298:267];

   assign w_sel    = (mode_ff == MODE_IMAG) ? f_weight_imag : f_weight;
   assign ax_pos   = pos_ff[axis_ff];
   assign ax_org   = org_ff[axis_ff];
   assign ax_inv   = inv_ff[axis_ff];
   assign ax_diff  = {ax_pos[31], ax_pos} - {ax_org[31], ax_org};
   assign cell_hi  = prod_ff[63:32];
   assign num_sum  = {prod_ff, 32'd0} + {32'd0, plo_ff};
   assign cap      = neg_ff ? TOP_NEG : TOP_POS;
   assign s_plus   = s_ff + BCNT_W'(1);

   always_comb begin
      case (axis_ff)
         2'd0:    ax_cells = 32'(CELLS_X);
         2'd1:    ax_cells = 32'(CELLS_Y);
         default: ax_cells = 32'(CELLS_Z);
      endcase
   end

   assign a0 = ADDR_W'(bin_ff) * ADDR_W'(CELLS_X) + cell_ff[0];
   assign a1 = a0 * ADDR_W'(CELLS_Y) + cell_ff[1];
   assign a2 = a1 * ADDR_W'(CELLS_Z) + cell_ff[2];

   assign old_ext = {{2{rdata_ff[VAL_W-1]}}, rdata_ff};
   assign sc_ext  = neg_ff ? (50'd0 - {2'b00, smag_ff}) : {2'b00, smag_ff};
   assign sum     = old_ext + sc_ext;

   always_comb begin
      if ($signed(sum) > $signed({2'b00, TOP_POS})) begin
         new_val = TOP_POS;
      end else if ($signed(sum) < $signed({2'b11, TOP_NEG})) begin
         new_val = TOP_NEG;
      end else begin
         new_val = sum[VAL_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      bu_in        = bu_ff;
      pos_in       = pos_ff;
      energy_in    = energy_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      f_in         = f_ff;
      tot_in       = tot_ff;
      s_in         = s_ff;
      lo_in        = lo_ff;
      bin_in       = bin_ff;
      axis_in      = axis_ff;
      cell_in      = cell_ff;
      addr_in      = addr_ff;
      phi_in       = phi_ff;
      plo_in       = plo_ff;
      smag_in      = smag_ff;
      rsp_score_in = rsp_score_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_val_in   = rsp_val_ff;
      mul_a        = mag_ff;
      mul_b        = f_ff;
      store_we     = 1'b0;
      store_wa     = addr_ff;
      store_wd     = new_val;
      store_ra     = addr_ff;
      bound_we     = 1'b0;
      bound_wa     = f_tidx[BIDX_W-1:0];
      bound_ra     = s_ff[BIDX_W-1:0];
      div_start    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            store_we = 1'b1;
            store_wa = clr_ff;
            store_wd = '0;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in    = f_pos;
               energy_in = f_energy;
               neg_in    = w_sel[31];
               mag_in    = w_sel[31] ? (32'd0 - w_sel) : w_sel;
               tot_in    = f_total;
               case (mode_ff)
                  MODE_TOTAL: f_in = f_total;
                  MODE_ELASTIC, MODE_ABSORB, MODE_FISSION, MODE_MT: f_in = f_react;
                  default: f_in = ONE_Q16;
               endcase
               rsp_score_in = 1'b0;
               rsp_addr_in  = '0;
               rsp_val_in   = '0;
               case (cmd_type'(req_tuser))
                  CMD_SCORE: begin
                     if (bu_ff < BCNT_W'(2)) begin
                        state_in = ST_OUT;
                     end else begin
                        s_in     = '0;
                        bound_ra = '0;
                        state_in = ST_BIN_CMP;
                     end
                  end
                  CMD_LOAD: begin
                     if (f_tidx < ADDR_W'(BOUND_SLOTS)) begin
                        bound_we = 1'b1;
                        bu_in    = BCNT_W'(f_tidx) + BCNT_W'(1);
                     end
                     rsp_addr_in = f_tidx;
                     state_in    = ST_OUT;
                  end
                  CMD_READ: begin
                     store_ra    = f_tidx;
                     rsp_addr_in = f_tidx;
                     state_in    = ST_ENT_Q;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_BIN_CMP: begin
            if (s_ff == '0) begin
               lo_in    = bound_q_ff;
               s_in     = s_plus;
               bound_ra = s_plus[BIDX_W-1:0];
            end else if (lo_ff <= energy_ff && energy_ff <= bound_q_ff) begin
               bin_in   = s_ff - BCNT_W'(1);
               axis_in  = 2'd0;
               state_in = ST_AX_MUL;
            end else if (s_plus == bu_ff) begin
               state_in = ST_OUT;
            end else begin
               lo_in    = bound_q_ff;
               s_in     = s_plus;
               bound_ra = s_plus[BIDX_W-1:0];
            end
         end
         ST_AX_MUL: begin
            mul_a = ax_diff[31:0];
            mul_b = ax_inv;
            if (ax_diff[32]) begin
               if (ax_inv != 32'd0) begin
                  state_in = ST_OUT;
               end else begin
                  cell_in[axis_ff] = '0;
                  axis_in          = axis_ff + 2'd1;
                  state_in         = (axis_ff == 2'd2) ? ST_MAG : ST_AX_MUL;
               end
            end else begin
               state_in = ST_AX_CHK;
            end
         end
         ST_AX_CHK: begin
            if (cell_hi >= ax_cells) begin
               state_in = ST_OUT;
            end else begin
               cell_in[axis_ff] = cell_hi[ADDR_W-1:0];
               axis_in          = axis_ff + 2'd1;
               state_in         = (axis_ff == 2'd2) ? ST_MAG : ST_AX_MUL;
            end
         end
         ST_MAG: begin
            addr_in  = a2;
            state_in = ST_PLO;
         end
         ST_PLO: begin
            mul_a    = prod_ff[31:0];
            mul_b    = inw_ff;
            phi_in   = prod_ff[63:32];
            state_in = ST_PHI;
         end
         ST_PHI: begin
            mul_a    = phi_ff;
            mul_b    = inw_ff;
            plo_in   = prod_ff;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            if (tot_ff == 32'd0) begin
               smag_in  = (num_sum == '0) ? '0 : cap;
               state_in = ST_RD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               smag_in  = div_quo;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            store_we     = 1'b1;
            rsp_score_in = 1'b1;
            rsp_addr_in  = addr_ff;
            rsp_val_in   = new_val;
            state_in     = ST_OUT;
         end
         ST_ENT_Q: begin
            rsp_val_in = rdata_ff;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         bu_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         bu_ff    <= bu_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      energy_ff    <= energy_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      f_ff         <= f_in;
      tot_ff       <= tot_in;
      s_ff         <= s_in;
      lo_ff        <= lo_in;
      bin_ff       <= bin_in;
      axis_ff      <= axis_in;
      cell_ff      <= cell_in;
      addr_ff      <= addr_in;
      phi_ff       <= phi_in;
      plo_ff       <= plo_in;
      smag_ff      <= smag_in;
      rsp_score_ff <= rsp_score_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_val_ff   <= rsp_val_in;
      prod_ff      <= 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FLUX;
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         inv_ff[0] <= ONE_Q16;
         inv_ff[1] <= ONE_Q16;
         inv_ff[2] <= ONE_Q16;
         inw_ff    <= ONE_Q16;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE:     mode_ff   <= csr_data[2:0];
            REG_ORIGIN_X: org_ff[0] <= csr_data;
            REG_ORIGIN_Y: org_ff[1] <= csr_data;
            REG_ORIGIN_Z: org_ff[2] <= csr_data;
            REG_INV_X:    inv_ff[0] <= csr_data;
            REG_INV_Y:    inv_ff[1] <= csr_data;
            REG_INV_Z:    inv_ff[2] <= csr_data;
            REG_INV_NET:  inw_ff    <= csr_data;
            default:      mode_ff   <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      rdata_ff <= store_mem[store_ra];
   end

   always_ff @(posedge clock) begin
      if (bound_we) begin
         bound_mem[bound_wa] <= f_tval;
      end
      bound_q_ff <= bound_mem[bound_ra];
   end

   cmts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_sum),
      .den   ({tot_ff, 16'd0}),
      .cap   (cap),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, rsp_val_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_score_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

[rtl/cmts_check.sv]
// Port-level checks of the tally scorer and their binding to the top level.
`default_nettype none
module cmts_check (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata,
   input wire logic [0:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result word changed while stalled.");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Input accepted again before the word in work finished.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("Input ready while a result word is pending.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("Block not quiet after reset.");

endmodule

bind collision_mesh_tally_scorer_top cmts_check u_cmts_check (.*);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the collision mesh tally scorer with its own scoring model.
`timescale 1ns / 100ps

module tb_top;
   import cmts_pkg::*;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] energy;
      logic [31:0] weight;
      logic [31:0] weight_imag;
      logic [31:0] total_xs;
      logic [31:0] reaction_xs;
      logic [10:0] table_index;
      logic [31:0] table_value;
   } collision_t;

   typedef struct packed {
      logic        scored;
      logic [10:0] bin_address;
      logic [47:0] tally_value;
   } tally_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [303:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   collision_mesh_tally_scorer_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Model state mirrored from the block.
   logic [2:0]  mode_reg;
   logic [31:0] origin_reg [3];
   logic [31:0] inv_reg [3];
   logic [31:0] net_reg;
   logic [47:0] tally_mem [STORE_DEPTH];
   logic [31:0] bound_mem [BOUND_SLOTS];
   int          bounds_used;
   int          bounds_written;

   tally_word_t expected_words [$];
   int  mismatch_count = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;

   function automatic bit mesh_cell(logic [31:0] pos, logic [31:0] org, logic [31:0] inv,
                                    int cells, output longint unsigned cell_idx);
      longint d;
      longint unsigned c;
      d = longint'($signed(pos)) - longint'($signed(org));
      if (d < 0) begin
         if (inv != 0) return 1'b0;
         c = 0;
      end else begin
         c = (longint'(d) * longint'({32'd0, inv})) >> 32;
      end
      cell_idx = c;
      return c < cells;
   endfunction

   function automatic tally_word_t tally_update(collision_t c);
      tally_word_t r;
      int bin;
      longint unsigned ci, cj, ck, mag, f, p, cap;
      logic [127:0] num, q;
      longint w, v;
      bit neg;
      logic [10:0] addr;
      r = '0;
      bin = -1;
      for (int e = 0; e + 1 < bounds_used && e + 1 < BOUND_SLOTS; e++) begin
         if (bin < 0 && bound_mem[e] <= c.energy && c.energy <= bound_mem[e+1]) bin = e;
      end
      if (bin < 0) return r;
      if (!mesh_cell(c.pos_x, origin_reg[0], inv_reg[0], CELLS_X, ci)) return r;
      if (!mesh_cell(c.pos_y, origin_reg[1], inv_reg[1], CELLS_Y, cj)) return r;
      if (!mesh_cell(c.pos_z, origin_reg[2], inv_reg[2], CELLS_Z, ck)) return r;
      w = longint'($signed(mode_reg == MODE_IMAG ? c.weight_imag : c.weight));
      if (mode_reg == MODE_TOTAL) f = c.total_xs;
      else if (mode_reg >= MODE_ELASTIC && mode_reg <= MODE_MT) f = c.reaction_xs;
      else f = ONE_Q16;
      neg = w < 0;
      mag = neg ? -w : w;
      cap = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
      p = mag * f;
      if (p == 0 || net_reg == 0) mag = 0;
      else if (c.total_xs == 0) mag = cap;
      else begin
         num = 128'(p) * 128'(net_reg);
         q = num / (128'(c.total_xs) << 16);
         mag = (q > 128'(cap)) ? cap : q[63:0];
      end
      addr = 11'((((bin * CELLS_X + ci) * CELLS_Y + cj) * CELLS_Z + ck));
      v = longint'($signed(tally_mem[addr])) + (neg ? -longint'(mag) : longint'(mag));
      if (v > longint'((64'd1 << 47) - 1)) v = (64'd1 << 47) - 1;
      if (v < -longint'(64'd1 << 47)) v = -longint'(64'd1 << 47);
      tally_mem[addr] = v[47:0];
      r.scored = 1'b1;
      r.bin_address = addr;
      r.tally_value = v[47:0];
      return r;
   endfunction

   function automatic tally_word_t predict_word(collision_t c);
      tally_word_t r;
      r = '0;
      case (c.cmd)
         CMD_SCORE: r = tally_update(c);
         CMD_LOAD: begin
            if (c.table_index < BOUND_SLOTS) begin
               bound_mem[c.table_index] = c.table_value;
               bounds_used = c.table_index + 1;
               if (bounds_written < bounds_used) bounds_written = bounds_used;
            end
            r.bin_address = c.table_index;
         end
         CMD_READ: begin
            r.bin_address = c.table_index;
            r.tally_value = tally_mem[c.table_index];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
   end

   always @(posedge clock) begin
      tally_word_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Result word with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tuser[0] !== want.scored || rsp_tdata[10:0] !== want.bin_address ||
                   rsp_tdata[58:11] !== want.tally_value || rsp_tdata[63:59] !== 5'd0) begin
                  if (mismatch_count < 10)
                     $display("Mismatch: scored %b/%b addr %0d/%0d value %h/%h (exp/act)",
                              want.scored, rsp_tuser[0], want.bin_address, rsp_tdata[10:0],
                              want.tally_value, rsp_tdata[58:11]);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= (stall_left == 0) && (calm || $urandom_range(99) >= 19);
      end
   end

   task automatic send_word(collision_t c);
      if (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.cmd;
      req_tdata <= {5'd0, c.table_value, c.table_index, c.reaction_xs, c.total_xs,
                    c.weight_imag, c.weight, c.energy, c.pos_z, c.pos_y, c.pos_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(predict_word(c));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_MODE:     mode_reg = value[2:0];
         REG_ORIGIN_X: origin_reg[0] = value;
         REG_ORIGIN_Y: origin_reg[1] = value;
         REG_ORIGIN_Z: origin_reg[2] = value;
         REG_INV_X:    inv_reg[0] = value;
         REG_INV_Y:    inv_reg[1] = value;
         REG_INV_Z:    inv_reg[2] = value;
         default:      net_reg = value;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [2:0] mode, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                            logic [31:0] net);
      drain();
      write_reg(REG_MODE, {29'd0, mode});
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz);
      write_reg(REG_INV_X, ix);
      write_reg(REG_INV_Y, iy);
      write_reg(REG_INV_Z, iz);
      write_reg(REG_INV_NET, net);
   endtask

   function automatic logic [31:0] axis_position(int ax);
      longint unsigned span;
      logic [31:0] d;
      if (inv_reg[ax] == 0) return $urandom;
      span = ((64'd8 << 32) - 1) / inv_reg[ax];
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      case ($urandom_range(19))
         0: d = -$urandom_range(1, 1000);
         1: d = 32'(span) + $urandom_range(1, 1000);
         default: d = $urandom_range(32'(span), 0);
      endcase
      return origin_reg[ax] + d;
   endfunction

   function automatic logic [31:0] random_xs();
      if ($urandom_range(9) == 0) return 32'd0;
      return $urandom >> $urandom_range(31, 0);
   endfunction

   function automatic collision_t random_collision();
      collision_t c;
      int e, slot;
      logic [31:0] lo, hi;
      c.cmd = CMD_SCORE;
      c.pos_x = axis_position(0);
      c.pos_y = axis_position(1);
      c.pos_z = axis_position(2);
      c.energy = $urandom;
      if (bounds_used >= 2) begin
         e = $urandom_range(bounds_used - 2, 0);
         lo = bound_mem[e];
         hi = bound_mem[e+1];
         if (lo > hi) begin lo = bound_mem[e+1]; hi = bound_mem[e]; end
         if ($urandom_range(9) != 0) c.energy = $urandom_range(hi, lo);
      end
      c.weight = $urandom_range(1) ? $urandom : $urandom_range(1 << 20, 0) - (1 << 19);
      c.weight_imag = $urandom_range(1) ? $urandom : $urandom_range(1 << 20, 0) - (1 << 19);
      c.total_xs = random_xs();
      c.reaction_xs = random_xs();
      c.table_index = $urandom;
      c.table_value = $urandom;
      case ($urandom_range(99)) inside
         [0:69]: ;
         [70:74]: begin c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom; end
         [75:82]: begin
            c.cmd = CMD_LOAD;
            slot = $urandom_range(bounds_written < BOUND_SLOTS ? bounds_written :
                                  BOUND_SLOTS - 1, 0);
            c.table_index = slot;
            if (slot > 0 && $urandom_range(3) != 0)
               c.table_value = bound_mem[slot-1] + $urandom_range(1 << 22, 0);
         end
         [83:84]: begin
            c.cmd = CMD_LOAD;
            c.table_index = $urandom_range(2047, BOUND_SLOTS);
         end
         [85:96]: c.cmd = CMD_READ;
         default: c.cmd = CMD_NONE;
      endcase
      return c;
   endfunction

   function automatic collision_t make_score(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] en,
                                             logic [31:0] w, logic [31:0] txs);
      collision_t c;
      c = '0;
      c.cmd = CMD_SCORE;
      c.pos_x = px; c.pos_y = py; c.pos_z = pz;
      c.energy = en; c.weight = w; c.weight_imag = ~w;
      c.total_xs = txs; c.reaction_xs = 32'h0002_8000;
      return c;
   endfunction

   function automatic collision_t make_table(cmd_type cmd, logic [10:0] idx, logic [31:0] v);
      collision_t c;
      c = '0;
      c.cmd = cmd;
      c.table_index = idx;
      c.table_value = v;
      return c;
   endfunction

   task automatic test_reset_state();
      send_word(make_table(CMD_READ, 11'd0, 0));
      send_word(make_table(CMD_READ, 11'd2047, 0));
      send_word(make_score(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'd5, 32'h1_0000, 32'h1_0000));
      send_word(make_table(CMD_NONE, 11'h7FF, 32'hFFFF_FFFF));
   endtask

   task automatic test_bounds_and_edges();
      send_word(make_table(CMD_LOAD, 11'd0, 32'd100));
      send_word(make_table(CMD_LOAD, 11'd1, 32'd1000));
      send_word(make_table(CMD_LOAD, 11'd2, 32'd5000));
      send_word(make_table(CMD_LOAD, 11'd3, 32'd70000));
      send_word(make_table(CMD_LOAD, 11'd4, 32'hFFFF_FFFF));
      send_word(make_table(CMD_LOAD, 11'd5, 32'd7));
      send_word(make_table(CMD_LOAD, 11'd2047, 32'd9));
      send_word(make_score(32'd0, 32'd0, 32'd0, 32'd100, 32'h1_0000, 32'h1_0000));
      send_word(make_score(32'h7_FFFF, 32'h7_FFFF, 32'h7_FFFF, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'h1_0000));
      send_word(make_score(32'h8_0000, 32'd0, 32'd0, 32'd500, 32'h1_0000, 32'h1_0000));
      send_word(make_score(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd500, 32'h1_0000, 32'h1_0000));
      send_word(make_score(32'd0, 32'd0, 32'd0, 32'd99, 32'h1_0000, 32'h1_0000));
      send_word(make_score(32'd0, 32'h1_0000, 32'd0, 32'd5000, 32'h8000_0000, 32'd1));
      send_word(make_score(32'd0, 32'h1_0000, 32'd0, 32'd5000, 32'h7FFF_FFFF, 32'd0));
      send_word(make_score(32'd0, 32'h1_0000, 32'd0, 32'd5000, 32'h8000_0000, 32'd0));
      send_word(make_score(32'd0, 32'h1_0000, 32'd0, 32'd5000, 32'd0, 32'd0));
      send_word(make_score(32'd0, 32'h2_0000, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_table(CMD_READ, 11'd8, 0));
   endtask

   task automatic test_random_phase(int count);
      for (int n = 0; n < count; n++) send_word(random_collision());
   endtask

   task automatic test_backpressure();
      calm = 1'b1;
      stall_left <= 400;
      test_random_phase(60);
      calm = 1'b0;
   endtask

   task automatic test_registers();
      configure(MODE_IMAG, 32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      test_random_phase(250);
      configure(MODE_TOTAL, 32'h7FFF_FFFF, 32'h0001_8000, 32'h8000_0000,
                32'h0000_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000);
      test_random_phase(150);
      for (int m = 1; m <= 6; m++) begin
         if (m == 4) continue;
         configure(3'(m), $urandom_range(1 << 20, 0) - (1 << 19), 32'd0, 32'hFFFF_0000,
                   32'h0001_0000, 32'h0000_4000, $urandom_range(1 << 18, 1 << 14),
                   $urandom);
         test_random_phase(180);
      end
      configure(MODE_FLUX, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000);
      test_random_phase(150);
   endtask

   initial begin
      mode_reg = MODE_FLUX;
      for (int a = 0; a < 3; a++) begin
         origin_reg[a] = '0;
         inv_reg[a] = ONE_Q16;
      end
      net_reg = ONE_Q16;
      foreach (tally_mem[a]) tally_mem[a] = '0;
      foreach (bound_mem[a]) bound_mem[a] = '0;
      bounds_used = 0;
      bounds_written = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_bounds_and_edges();
      test_random_phase(200);
      test_backpressure();
      test_registers();
      drain();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
rtl/cmts_pkg.sv
rtl/cmts_div.sv
rtl/collision_mesh_tally_scorer_top.sv
rtl/cmts_check.sv
tb/tb_top.sv
